@@ rtl/ksa_pkg.sv @@
// Shared types and constants for the key scan / auto-repeat block.
// No dependencies; used by every module under rtl/.
package ksa_pkg;

	localparam int KEY_W   = 32;   // key word width on the stream
	localparam int DELTA_W = 16;   // elapsed_ticks width
	localparam int ADD_W   = 16;   // lock_add width
	localparam int THR_W   = 16;   // repeat_threshold width
	localparam int LOCK_W  = 32;   // lock countdown width
	localparam int IN_W    = KEY_W + DELTA_W + ADD_W;
	localparam int OUT_W   = 3 * KEY_W;

	localparam logic [THR_W-1:0] THR_RESET = 16'd250;

	// Per-poll control broadcast to every key lane.
	typedef struct packed {
		logic               step;   // accepted poll that samples the keys
		logic [DELTA_W-1:0] delta;
		logic [THR_W-1:0]   thr;
	} lane_ctrl_t;

endpackage

@@ rtl/ksa_lane.sv @@
// One key lane: saturating hold counter and threshold flag.
// Depends on ksa_pkg.
module ksa_lane #(
	parameter int DURATION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ksa_pkg::lane_ctrl_t ctrl,
	input  logic               diff,     // key changed at this sample
	output logic               reached   // updated counter >= threshold
);

	localparam int CW = (DURATION_BITS > ksa_pkg::THR_W) ? DURATION_BITS : ksa_pkg::THR_W;
	localparam int SW = CW + 1;

	logic [DURATION_BITS-1:0] cnt_q;
	logic [DURATION_BITS-1:0] cnt_next;
	logic [SW-1:0]            sum;
	logic                     below;

	assign below = CW'(cnt_q) < CW'(ctrl.thr);
	assign sum   = SW'(cnt_q) + SW'(ctrl.delta);

	always_comb begin
		cnt_next = cnt_q;
		if (diff) begin
			cnt_next = '0;
		end else if (below) begin
			if (sum[SW-1:DURATION_BITS] != '0)
				cnt_next = '1;
			else
				cnt_next = sum[DURATION_BITS-1:0];
		end
	end

	assign reached = CW'(cnt_next) >= CW'(ctrl.thr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (ctrl.step)
			cnt_q <= cnt_next;
	end

endmodule

@@ rtl/ksa_lock.sv @@
// Input lock countdown with saturating add.
// Depends on ksa_pkg.
module ksa_lock (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,    // poll accepted
	input  logic [ksa_pkg::DELTA_W-1:0] delta,
	input  logic [ksa_pkg::ADD_W-1:0]   add,
	output logic                        locked   // poll only updates the lock
);

	localparam int LW = ksa_pkg::LOCK_W;

	logic [LW-1:0] lock_q;
	logic [LW:0]   run;
	logic [LW-1:0] lock_next;

	assign locked = LW'(delta) < lock_q;
	// lock - delta stays positive while locked, so one three-input add
	assign run = {1'b0, lock_q} - (LW+1)'(delta) + (LW+1)'(add);

	always_comb begin
		if (!locked)
			lock_next = LW'(add);
		else if (run[LW])
			lock_next = '1;
		else
			lock_next = run[LW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			lock_q <= '0;
		else if (take)
			lock_q <= lock_next;
	end

endmodule

@@ rtl/ksa_merge.sv @@
// Merge stage: folds lane flags into the result masks and holds the
// output register. Depends on ksa_pkg.
module ksa_merge (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      take,
	input  logic                      locked,
	input  logic [ksa_pkg::KEY_W-1:0] changed,
	input  logic [ksa_pkg::KEY_W-1:0] pressed,
	input  logic [ksa_pkg::KEY_W-1:0] reached,
	output logic                      in_ready,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [ksa_pkg::OUT_W-1:0] out_data
);

	logic                      valid_q;
	logic [ksa_pkg::OUT_W-1:0] data_q;
	logic [ksa_pkg::KEY_W-1:0] rep;

	assign rep      = pressed & (changed | reached);
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (in_ready)
			valid_q <= take;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (locked)
				data_q <= '0;
			else
				data_q <= {rep, pressed, changed};
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

@@ rtl/key_scan_autorepeat_top.sv @@
// Key scan with hold timing and auto-repeat: one poll in, one result out.
// A poll is taken every clock cycle and its masks appear in the output
// register in the following cycle; the only stall is a full output register that
// the sink does not take. That rate comes from the per-key lanes, which
// update all hold counters in the accepting cycle (one add, saturate and
// compare each), and from the lock compare and update in that same cycle.
// s_axis_tdata: key_bits[31:0], elapsed_ticks[47:32], lock_add[63:48].
// m_axis_tdata: changed_mask[31:0], pressed_mask[63:32], repeat_mask[95:64].
// A locked poll (lock > elapsed_ticks) only counts the lock down (adding lock_add)
// and returns all-zero masks. repeat_threshold is written via cfg_we/cfg_data
// (reset 250); the user must write it only while the block is idle, which the block does not enforce.
module key_scan_autorepeat_top #(
	parameter int NUM_KEYS      = 32,
	parameter int DURATION_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// config
	input  logic                        cfg_we,
	input  logic [ksa_pkg::THR_W-1:0]   cfg_data,   // repeat_threshold
	// poll stream
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [ksa_pkg::IN_W-1:0]    s_axis_tdata,  // key_bits, elapsed_ticks, lock_add
	// result stream
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [ksa_pkg::OUT_W-1:0]   m_axis_tdata   // changed, pressed, repeat masks
);

	localparam int KW = ksa_pkg::KEY_W;

	logic [ksa_pkg::THR_W-1:0]   thr_q;
	logic [NUM_KEYS-1:0]         cur_q;     // last sampled keys
	logic [NUM_KEYS-1:0]         keys_new;
	logic [NUM_KEYS-1:0]         diff;
	logic [NUM_KEYS-1:0]         lane_hit;
	logic [KW-1:0]               changed32;
	logic [KW-1:0]               pressed32;
	logic [KW-1:0]               reached32;
	logic [ksa_pkg::DELTA_W-1:0] delta;
	logic [ksa_pkg::ADD_W-1:0]   add;
	logic                        take;
	logic                        locked;
	ksa_pkg::lane_ctrl_t         ctrl;

	assign delta = s_axis_tdata[KW +: ksa_pkg::DELTA_W];
	assign add   = s_axis_tdata[KW + ksa_pkg::DELTA_W +: ksa_pkg::ADD_W];
	assign take  = s_axis_tvalid && s_axis_tready;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			thr_q <= ksa_pkg::THR_RESET;
		else if (cfg_we)
			thr_q <= cfg_data;
	end

	// keys beyond the key word never press; bits beyond NUM_KEYS are dropped
	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_keys
		if (k < KW) begin : g_in
			assign keys_new[k] = s_axis_tdata[k];
		end else begin : g_none
			assign keys_new[k] = 1'b0;
		end
	end

	assign diff = keys_new ^ cur_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cur_q <= '0;
		else if (ctrl.step)
			cur_q <= keys_new;
	end

	// lock countdown
	ksa_lock u_lock (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.delta  (delta),
		.add    (add),
		.locked (locked)
	);

	assign ctrl.step  = take && !locked;
	assign ctrl.delta = delta;
	assign ctrl.thr   = thr_q;

	// one lane per key
	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
		ksa_lane #(
			.DURATION_BITS (DURATION_BITS)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.diff    (diff[k]),
			.reached (lane_hit[k])
		);
	end

	// map lanes onto the fixed 32-bit result word
	for (genvar b = 0; b < KW; b++) begin : g_map
		if (b < NUM_KEYS) begin : g_lane_bit
			assign changed32[b] = diff[b];
			assign pressed32[b] = keys_new[b];
			assign reached32[b] = lane_hit[b];
		end else begin : g_zero
			assign changed32[b] = 1'b0;
			assign pressed32[b] = 1'b0;
			assign reached32[b] = 1'b0;
		end
	end

	ksa_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.locked    (locked),
		.changed   (changed32),
		.pressed   (pressed32),
		.reached   (reached32),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

	// an accepted poll always lands in the output register
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> m_axis_tvalid)
		else $error("accepted poll produced no result");

	// repeat only for pressed keys
	a_rep_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata[3*KW-1:2*KW] & ~m_axis_tdata[2*KW-1:KW]) == '0))
		else $error("repeat bit set for a released key");

	// a fresh press always repeats
	a_press_rep: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata[KW-1:0] & m_axis_tdata[2*KW-1:KW]
			& ~m_axis_tdata[3*KW-1:2*KW]) == '0))
		else $error("new press missing from repeat mask");

	// an empty output register never stalls the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output register");

endmodule
